FILE: rtl/plst_pkg.sv
// ============================================================================
// plst_pkg
// Shared types and constants for the positional list engine.
// ============================================================================
package plst_pkg;

    // Number of entries the list can hold.
    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of the item formats.
    localparam int OP_W   = 2;
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;
    localparam int EPOS_W = 5;
    localparam int ECNT_W = 6;
    localparam int ERR_W  = 2;

    // Width used to compare a requested position against the count.
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [OP_W-1:0]  opcode_t;
    typedef logic [ERR_W-1:0] err_t;

    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_REMOVE = 2'd1;
    localparam opcode_t OP_CLEAR  = 2'd2;
    localparam opcode_t OP_DUMP   = 2'd3;

    localparam err_t ERR_OK    = 2'd0;
    localparam err_t ERR_RANGE = 2'd1;
    localparam err_t ERR_FULL  = 2'd2;

    typedef struct packed {
        opcode_t                  opcode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] element_value;
        logic [EPOS_W-1:0]        element_position;
        logic                     has_element;
        logic [ECNT_W-1:0]        entry_count;
        err_t                     error_code;
        logic                     last;
    } out_item_t;

    // Access request from the sequencer to the entry store.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

FILE: rtl/plst_ram.sv
// ============================================================================
// plst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module plst_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 5,
    parameter int DEPTH  = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/plst_ctrl.sv
// ============================================================================
// plst_ctrl
// Sequencer: validates each item, walks the entry store to shift entries
// for insert and remove, and streams entries out for a dump.
// ============================================================================
module plst_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  plst_pkg::in_item_t              s_item,
    output logic                            res_valid,
    input  logic                            res_ready,
    output plst_pkg::out_item_t             res_item,
    output plst_pkg::mem_req_t              mem_req,
    input  logic [plst_pkg::DATA_W-1:0]     mem_rdata
);
    import plst_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INS  = 3'd1;
    localparam logic [2:0] ST_REM  = 3'd2;
    localparam logic [2:0] ST_DUMP = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] lim_reg, lim_next;
    logic [DATA_W-1:0] val_reg, val_next;
    err_t              err_reg, err_next;

    logic [CMP_W-1:0]  pos_cmp;
    logic [CMP_W-1:0]  cnt_cmp;
    logic              cnt_full;
    logic [ADDR_W-1:0] cnt_dec;

    assign pos_cmp  = CMP_W'(s_item.position);
    assign cnt_cmp  = CMP_W'(count_reg);
    assign cnt_full = (count_reg == CNT_W'(DEPTH));
    assign cnt_dec  = ADDR_W'(count_reg - CNT_W'(1));

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        lim_next   = lim_reg;
        val_next   = val_reg;
        err_next   = err_reg;

        s_ready    = (state_reg == ST_IDLE);
        mem_req    = '0;
        mem_req.raddr = ptr_reg;

        res_valid  = 1'b0;
        res_item   = '0;
        res_item.entry_count = ECNT_W'(count_reg);
        res_item.error_code  = err_reg;
        res_item.last        = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    err_next   = ERR_OK;
                    state_next = ST_RESP;
                    unique case (s_item.opcode)
                        OP_INSERT: begin
                            if (pos_cmp > cnt_cmp) begin
                                err_next = ERR_RANGE;
                            end else if (cnt_full) begin
                                err_next = ERR_FULL;
                            end else begin
                                ptr_next      = ADDR_W'(count_reg);
                                pos_next      = ADDR_W'(s_item.position);
                                val_next      = s_item.value;
                                mem_req.raddr = cnt_dec;
                                state_next    = ST_INS;
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_cmp >= cnt_cmp) begin
                                err_next = ERR_RANGE;
                            end else begin
                                ptr_next      = ADDR_W'(s_item.position);
                                lim_next      = cnt_dec;
                                mem_req.raddr = ADDR_W'(s_item.position) + ADDR_W'(1);
                                state_next    = ST_REM;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_DUMP: begin
                            if (count_reg != '0) begin
                                ptr_next      = cnt_dec;
                                mem_req.raddr = cnt_dec;
                                state_next    = ST_DUMP;
                            end
                        end
                    endcase
                end
            end

            // Walk down from the top: the entry read last cycle moves up by one.
            ST_INS: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg;
                if (ptr_reg == pos_reg) begin
                    mem_req.wdata = val_reg;
                    count_next    = count_reg + CNT_W'(1);
                    state_next    = ST_RESP;
                end else begin
                    mem_req.wdata = mem_rdata;
                    mem_req.raddr = ptr_reg - ADDR_W'(2);
                    ptr_next      = ptr_reg - ADDR_W'(1);
                end
            end

            // Walk up from the gap: the entry read last cycle moves down by one.
            ST_REM: begin
                if (ptr_reg == lim_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_RESP;
                end else begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = ptr_reg;
                    mem_req.wdata = mem_rdata;
                    mem_req.raddr = ptr_reg + ADDR_W'(2);
                    ptr_next      = ptr_reg + ADDR_W'(1);
                end
            end

            // Read data for ptr_reg is present; prefetch the next lower entry
            // in the same cycle the current one is taken.
            ST_DUMP: begin
                res_valid                 = 1'b1;
                res_item.element_value    = mem_rdata;
                res_item.element_position = EPOS_W'(ptr_reg);
                res_item.has_element      = 1'b1;
                res_item.error_code       = ERR_OK;
                res_item.last             = (ptr_reg == '0);
                if (res_ready) begin
                    if (ptr_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next      = ptr_reg - ADDR_W'(1);
                        mem_req.raddr = ptr_reg - ADDR_W'(1);
                    end
                end
            end

            ST_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        pos_reg <= pos_next;
        lim_reg <= lim_next;
        val_reg <= val_next;
        err_reg <= err_next;
    end

    // The count never grows beyond the store.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds store depth");

    // The insert walk never passes below the insert position.
    a_ins_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS) |-> (ptr_reg >= pos_reg))
        else $error("insert walk passed its position");

    // The remove walk never passes the last entry.
    a_rem_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REM) |-> (ptr_reg <= lim_reg))
        else $error("remove walk passed the last entry");

    // A dump only reads the store.
    a_dump_ro: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |-> !mem_req.we)
        else $error("store written during dump");

    // A clear empties the list at once.
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_item.opcode == OP_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the list");

endmodule

FILE: rtl/positional_list_engine_top.sv
// ============================================================================
// positional_list_engine_top
// Ordered list of signed 32-bit values with positional insert and remove.
// ============================================================================
// The block keeps an ordered list of up to DEPTH (32) signed values in one
// synchronous RAM and takes one item at a time. Insert at position p walks
// the RAM from the top entry down to p, moving each entry up by one at one
// entry per cycle; remove at p walks up from p. A dump streams one item per
// cycle, while the result side does not stall, from the highest position
// down to 0. Each insert, remove or clear gives one result item carrying the
// new count and an error code (position out of range, or list full); a dump
// of an empty list gives one result item with no element. The final result
// item of every input item has last set. Results leave through a registered
// output stage, so the next input item can be taken while a result is still
// waiting. The RAM needs no clearing after reset: only entries below the
// count are ever used, and those have always been written.
// ============================================================================
module positional_list_engine_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  plst_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output plst_pkg::out_item_t  m_item
);
    import plst_pkg::*;

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rdata;

    logic      res_valid;
    logic      res_ready;
    out_item_t res_item;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg, m_item_next;

    // Entry store.
    plst_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // Command sequencer.
    plst_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // Output register: it accepts a new result item whenever it is empty or
    // its current item leaves in the same cycle.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_item_next = res_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

FILE: tb/positional_list_engine_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// positional_list_engine_top_tb
// Self-checking bench for the positional list engine.
// ============================================================================
// The bench drives list operations (insert, remove, clear, dump) through the
// input channel and checks every result item against a shadow copy of the
// list that the bench keeps itself. A short directed run covers the empty
// list, the value extremes, errors and dumps. A random run then follows,
// built from fill-to-full, drain-to-empty and mixed episodes. Both sides
// idle in random bursts, and the last stretch of the run has no idling.
// ============================================================================
module positional_list_engine_top_tb;
    import plst_pkg::*;

    // Idle cycles with no accepted item before the run is declared hung.
    localparam int HANG_LIMIT  = 2000;
    // Cycles to wait after the last expected result for stray results.
    localparam int SETTLE_WAIT = 64;
    // Number of random items and the point where idling stops.
    localparam int RANDOM_OPS  = 480;
    localparam int CALM_TAIL   = 50;

    typedef struct {
        in_item_t op;
        int       gap;
    } queued_op_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Operations waiting to be sent, and results still owed by the block.
    queued_op_t queued_ops[$];
    out_item_t  due_results[$];

    // Shadow of the list contents, updated as items are accepted.
    logic signed [DATA_W-1:0] list_shadow [DEPTH];
    int                       shadow_count = 0;

    // Entry count as seen by the stimulus generator, updated as operations are
    // queued, so that it can pick legal and illegal positions on purpose.
    int plan_count = 0;
    int ops_made   = 0;

    int fault_count = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    int cycle_no    = 0;

    positional_list_engine_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Shadow list: apply one accepted operation and queue the results that
    // the block owes for it.
    // ------------------------------------------------------------------------
    task automatic predict_list_op(input in_item_t op);
        out_item_t res;
        int        pos;
        err_t      err;
        pos = int'(op.position);
        err = ERR_OK;
        res = '0;
        res.last = 1'b1;
        case (op.opcode)
            OP_INSERT: begin
                // The range check wins over the full check.
                if (pos > shadow_count) begin
                    err = ERR_RANGE;
                end else if (shadow_count >= DEPTH) begin
                    err = ERR_FULL;
                end else begin
                    for (int i = shadow_count; i > pos; i--)
                        list_shadow[ADDR_W'(i)] = list_shadow[ADDR_W'(i-1)];
                    list_shadow[ADDR_W'(pos)] = op.value;
                    shadow_count++;
                end
            end
            OP_REMOVE: begin
                if (pos >= shadow_count) begin
                    err = ERR_RANGE;
                end else begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                        list_shadow[ADDR_W'(i)] = list_shadow[ADDR_W'(i+1)];
                    shadow_count--;
                end
            end
            OP_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
                // A dump of a non-empty list streams from the top entry down;
                // only the result for position 0 carries last.
                if (shadow_count > 0) begin
                    for (int p = shadow_count - 1; p >= 0; p--) begin
                        res.element_value    = list_shadow[ADDR_W'(p)];
                        res.element_position = EPOS_W'(p);
                        res.has_element      = 1'b1;
                        res.entry_count      = ECNT_W'(shadow_count);
                        res.error_code       = ERR_OK;
                        res.last             = (p == 0);
                        due_results.push_back(res);
                    end
                    return;
                end
            end
        endcase
        res.entry_count = ECNT_W'(shadow_count);
        res.error_code  = err;
        due_results.push_back(res);
    endtask

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fault_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Queues one operation and tracks the count it will leave behind. The
    // gap is the number of idle cycles the driver holds off before it.
    task automatic push_op(input opcode_t opc, input int pos,
                           input logic [DATA_W-1:0] val, input bit calm);
        queued_op_t q;
        q.op.opcode   = opc;
        q.op.position = POS_W'(pos);
        q.op.value    = val;
        if (calm || ops_made >= RANDOM_OPS - CALM_TAIL || $urandom_range(0, 3) != 0)
            q.gap = 0;
        else
            q.gap = $urandom_range(1, 14);
        queued_ops.push_back(q);
        ops_made++;
        if (opc == OP_INSERT && pos <= plan_count && plan_count < DEPTH)
            plan_count++;
        else if (opc == OP_REMOVE && pos < plan_count)
            plan_count--;
        else if (opc == OP_CLEAR)
            plan_count = 0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int  mode;
        int  n;
        int  w;
        bit  calm;

        // Directed part: empty-list cases first, then value extremes at the
        // ends and middle, out-of-range positions, and removes at the first,
        // middle and last positions, with dumps in between to see the order.
        push_op(OP_DUMP,   0,  pick_value(), 1'b0);
        push_op(OP_REMOVE, 0,  pick_value(), 1'b0);
        push_op(OP_CLEAR,  0,  pick_value(), 1'b0);
        push_op(OP_INSERT, 1,  32'h1234_5678, 1'b0);
        push_op(OP_INSERT, 0,  32'h7fff_ffff, 1'b0);
        push_op(OP_INSERT, 1,  32'h8000_0000, 1'b0);
        push_op(OP_INSERT, 0,  32'h0000_0000, 1'b0);
        push_op(OP_INSERT, 1,  32'hffff_ffff, 1'b0);
        push_op(OP_INSERT, 2,  32'h5555_5555, 1'b0);
        push_op(OP_DUMP,   63, 32'hffff_ffff, 1'b0);
        push_op(OP_REMOVE, 5,  pick_value(), 1'b0);
        push_op(OP_REMOVE, 63, pick_value(), 1'b0);
        push_op(OP_INSERT, 63, 32'haaaa_aaaa, 1'b0);
        push_op(OP_REMOVE, 4,  pick_value(), 1'b0);
        push_op(OP_REMOVE, 0,  pick_value(), 1'b0);
        push_op(OP_REMOVE, 1,  pick_value(), 1'b0);
        push_op(OP_DUMP,   0,  pick_value(), 1'b0);
        push_op(OP_CLEAR,  63, pick_value(), 1'b0);
        push_op(OP_DUMP,   0,  pick_value(), 1'b0);
        push_op(OP_INSERT, 0,  32'haaaa_aaaa, 1'b0);
        push_op(OP_DUMP,   0,  pick_value(), 1'b0);

        // Random part, in episodes. Some episodes run with no input gaps at all.
        ops_made = 0;
        while (ops_made < RANDOM_OPS) begin
            calm = ($urandom_range(0, 2) == 0);
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
                // Fill to full, then hit the full and past-count errors.
                while (plan_count < DEPTH)
                    push_op(OP_INSERT, $urandom_range(0, plan_count), pick_value(), calm);
                push_op(OP_INSERT, $urandom_range(0, DEPTH), pick_value(), calm);
                push_op(OP_INSERT, $urandom_range(DEPTH + 1, 63), pick_value(), calm);
                push_op(OP_DUMP, $urandom_range(0, 63), pick_value(), calm);
            end else if (mode < 4) begin
                // Drain to empty, then remove from the empty list.
                while (plan_count > 0)
                    push_op(OP_REMOVE, $urandom_range(0, plan_count - 1), pick_value(), calm);
                push_op(OP_REMOVE, $urandom_range(0, 63), pick_value(), calm);
                push_op(OP_DUMP, $urandom_range(0, 63), pick_value(), calm);
            end else begin
                // Mixed traffic, mostly legal operations.
                n = $urandom_range(8, 30);
                repeat (n) begin
                    w = $urandom_range(0, 99);
                    if (w < 45 && plan_count < DEPTH)
                        push_op(OP_INSERT, $urandom_range(0, plan_count), pick_value(), calm);
                    else if (w < 75 && plan_count > 0)
                        push_op(OP_REMOVE, $urandom_range(0, plan_count - 1), pick_value(),
                                calm);
                    else if (w < 83)
                        push_op(OP_INSERT, $urandom_range(plan_count + 1, 63), pick_value(),
                                calm);
                    else if (w < 88)
                        push_op(OP_REMOVE, $urandom_range(plan_count, 63), pick_value(), calm);
                    else if (w < 95)
                        push_op(OP_DUMP, $urandom_range(0, 63), pick_value(), calm);
                    else if (w < 97)
                        push_op(OP_CLEAR, $urandom_range(0, 63), pick_value(), calm);
                    else
                        push_op(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                                $urandom, calm);
                end
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every item is sent and every result has come back,
        // then leave time for any stray result to show up.
        while (queued_ops.size() != 0 || s_valid || due_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);

        if (fault_count == 0)
            $display("positional_list_engine_top: match");
        else
            $display("positional_list_engine_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: presents queued items, holding each one off for its gap first.
    // The shadow list is updated at the edge where an item is accepted.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_list_op(s_item);
            if (!s_valid || s_ready) begin
                if (queued_ops.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (queued_ops[0].gap > 0) begin
                    queued_ops[0].gap = queued_ops[0].gap - 1;
                    s_valid <= 1'b0;
                end else begin
                    s_item  <= queued_ops[0].op;
                    s_valid <= 1'b1;
                    void'(queued_ops.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side back-pressure. Stall bursts are switched off while bit 9 of
    // the cycle counter is set, and for good once the stimulus nears its end.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!cycle_no[9] && queued_ops.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
                stall_left <= $urandom_range(1, 14);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted result is matched against the oldest one owed.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: result with none outstanding: expected nothing actual %h",
                         $time, m_item);
                fault_count++;
            end else begin
                want = due_results.pop_front();
                compare_field("element_value", longint'(want.element_value),
                              longint'(m_item.element_value));
                compare_field("element_position", longint'(want.element_position),
                              longint'(m_item.element_position));
                compare_field("has_element", longint'(want.has_element),
                              longint'(m_item.has_element));
                compare_field("entry_count", longint'(want.entry_count),
                              longint'(m_item.entry_count));
                compare_field("error_code", longint'(want.error_code),
                              longint'(m_item.error_code));
                compare_field("last", longint'(want.last), longint'(m_item.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a long stretch with no item accepted on either side means the
    // block has hung.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= HANG_LIMIT) begin
                $display("%0t: no item accepted for %0d cycles", $time, HANG_LIMIT);
                $display("positional_list_engine_top: mismatch");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
